// ===== hw/rtl/tav_pkg.sv =====
package tav_pkg;

    // Default line store depth and fixed limits
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_TILE      = 16;
    localparam int HEIGHT_LIMIT  = 2048;

    // Field and state widths
    localparam int ROW_W   = 11;
    localparam int SEG_W   = 12;
    localparam int SUM_W   = 16;
    localparam int CHAR_W  = 7;
    localparam int BOUNDS  = 9;
    localparam int LEVELS  = 10;
    localparam int OUT_DEPTH = 4;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;

    // Register reset values
    localparam logic [4:0]  TILE_RESET   = 5'd10;
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_TILE_SIZE    = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_reg_t;

    // Level k holds while average <= bound k, i.e. total < (bound k + 1) * tile area
    localparam logic [8:0] LEVEL_LIMIT_BASE [BOUNDS] = '{
        9'd32, 9'd57, 9'd82, 9'd107, 9'd132, 9'd157, 9'd182, 9'd207, 9'd232
    };

    // Characters from dark to light: @%#*+=-:. and space
    localparam logic [CHAR_W-1:0] LEVEL_CHAR [LEVELS] = '{
        7'd64, 7'd37, 7'd35, 7'd42, 7'd43, 7'd61, 7'd45, 7'd58, 7'd46, 7'd32
    };

    // Clamped configuration
    typedef struct packed {
        logic [4:0]  tile_size;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
    } cfg_t;

    // Per-word command from the raster scan to the line store
    typedef struct packed {
        logic             tile_done;
        logic             add_mem;
        logic             emit;
        logic             newline;
        logic [SEG_W-1:0] seg;
    } scan_cmd_t;

    // Finished tile sum and the results it causes
    typedef struct packed {
        logic             emit;
        logic             newline;
        logic [SUM_W-1:0] total;
    } tile_res_t;

    // One result word in the output queue
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } out_word_t;

    // Tile area lookup for tile sizes 1..16
    function automatic logic [8:0] tile_square(input logic [4:0] ts);
        logic [8:0] sq;
        case (ts)
            5'd1:    sq = 9'd1;
            5'd2:    sq = 9'd4;
            5'd3:    sq = 9'd9;
            5'd4:    sq = 9'd16;
            5'd5:    sq = 9'd25;
            5'd6:    sq = 9'd36;
            5'd7:    sq = 9'd49;
            5'd8:    sq = 9'd64;
            5'd9:    sq = 9'd81;
            5'd10:   sq = 9'd100;
            5'd11:   sq = 9'd121;
            5'd12:   sq = 9'd144;
            5'd13:   sq = 9'd169;
            5'd14:   sq = 9'd196;
            5'd15:   sq = 9'd225;
            5'd16:   sq = 9'd256;
            default: sq = 9'd1;
        endcase
        return sq;
    endfunction

endpackage

// ===== hw/rtl/tav_scan.sv =====
module tav_scan #(
    parameter int  MAX_WIDTH = tav_pkg::MAX_WIDTH_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tav_pkg::cfg_t       cfg,
    input  logic                restart,
    input  logic                accept,
    input  logic [7:0]          pixel_value,
    output tav_pkg::scan_cmd_t  cmd,
    output logic [COL_W-1:0]    tile_idx
);

    localparam int XW = ((COL_W > 12) ? COL_W : 12) + 1;

    logic [COL_W-1:0]          col_pos_reg, col_pos_next;
    logic [COL_W-1:0]          col_start_reg, col_start_next;
    logic [COL_W-1:0]          tile_col_reg, tile_col_next;
    logic [3:0]                col_phase_reg, col_phase_next;
    logic [tav_pkg::ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [tav_pkg::ROW_W-1:0] row_start_reg, row_start_next;
    logic [3:0]                row_phase_reg, row_phase_next;
    logic [tav_pkg::SEG_W-1:0] seg_sum_reg, seg_sum_next;

    logic [XW-1:0]             ts_x;
    logic [XW-1:0]             w_x;
    logic [4:0]                ts_m1;
    logic                      in_col;
    logic                      in_row;
    logic                      row_end;
    logic                      frame_end;
    logic                      col_wrap;
    logic                      row_wrap;
    logic                      last_band_row;
    logic                      tile_done;
    logic [tav_pkg::SEG_W-1:0] seg;

    // Decode the position of this word against full tiles and frame edges
    always_comb begin
        ts_x          = XW'(cfg.tile_size);
        w_x           = XW'(cfg.frame_width);
        ts_m1         = cfg.tile_size - 5'd1;
        in_col        = (XW'(col_start_reg) + ts_x) <= w_x;
        in_row        = (12'(row_start_reg) + 12'(cfg.tile_size)) <= cfg.frame_height;
        row_end       = XW'(col_pos_reg) >= (w_x - XW'(1));
        frame_end     = 12'(row_pos_reg) >= (cfg.frame_height - 12'd1);
        col_wrap      = {1'b0, col_phase_reg} >= ts_m1;
        row_wrap      = {1'b0, row_phase_reg} >= ts_m1;
        last_band_row = in_row && ({1'b0, row_phase_reg} == ts_m1);
        tile_done     = in_row && in_col && ({1'b0, col_phase_reg} == ts_m1);
        seg           = seg_sum_reg + tav_pkg::SEG_W'(pixel_value);

        cmd.tile_done = tile_done;
        cmd.add_mem   = row_phase_reg != 4'd0;
        cmd.emit      = tile_done && last_band_row;
        cmd.newline   = row_end && last_band_row;
        cmd.seg       = seg;
        tile_idx      = tile_col_reg;
    end

    // Advance position, phases and the running segment sum
    always_comb begin
        col_pos_next   = col_pos_reg;
        col_start_next = col_start_reg;
        tile_col_next  = tile_col_reg;
        col_phase_next = col_phase_reg;
        row_pos_next   = row_pos_reg;
        row_start_next = row_start_reg;
        row_phase_next = row_phase_reg;
        seg_sum_next   = seg_sum_reg;

        if (accept) begin
            if (tile_done) begin
                seg_sum_next  = '0;
                tile_col_next = tile_col_reg + COL_W'(1);
            end else if (in_row && in_col) begin
                seg_sum_next = seg;
            end

            if (row_end) begin
                col_pos_next   = '0;
                col_start_next = '0;
                col_phase_next = '0;
                tile_col_next  = '0;
                seg_sum_next   = '0;
                if (frame_end) begin
                    row_pos_next   = '0;
                    row_start_next = '0;
                    row_phase_next = '0;
                end else begin
                    row_pos_next = row_pos_reg + tav_pkg::ROW_W'(1);
                    if (row_wrap) begin
                        row_phase_next = '0;
                        row_start_next = row_start_reg + tav_pkg::ROW_W'(cfg.tile_size);
                    end else begin
                        row_phase_next = row_phase_reg + 4'd1;
                    end
                end
            end else begin
                col_pos_next = col_pos_reg + COL_W'(1);
                if (col_wrap) begin
                    col_phase_next = '0;
                    col_start_next = col_start_reg + COL_W'(cfg.tile_size);
                end else begin
                    col_phase_next = col_phase_reg + 4'd1;
                end
            end
        end

        // A write to a defined register restarts the frame
        if (restart) begin
            col_pos_next   = '0;
            col_start_next = '0;
            tile_col_next  = '0;
            col_phase_next = '0;
            row_pos_next   = '0;
            row_start_next = '0;
            row_phase_next = '0;
            seg_sum_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg   <= '0;
            col_start_reg <= '0;
            tile_col_reg  <= '0;
            col_phase_reg <= '0;
            row_pos_reg   <= '0;
            row_start_reg <= '0;
            row_phase_reg <= '0;
            seg_sum_reg   <= '0;
        end else begin
            col_pos_reg   <= col_pos_next;
            col_start_reg <= col_start_next;
            tile_col_reg  <= tile_col_next;
            col_phase_reg <= col_phase_next;
            row_pos_reg   <= row_pos_next;
            row_start_reg <= row_start_next;
            row_phase_reg <= row_phase_next;
            seg_sum_reg   <= seg_sum_next;
        end
    end

endmodule

// ===== hw/rtl/tav_band_store.sv =====
module tav_band_store #(
    parameter int  MAX_WIDTH = tav_pkg::MAX_WIDTH_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  tav_pkg::scan_cmd_t  cmd,
    input  logic [COL_W-1:0]    tile_idx,
    output tav_pkg::tile_res_t  res
);

    logic [tav_pkg::SUM_W-1:0] band_mem [MAX_WIDTH];
    logic [tav_pkg::SUM_W-1:0] rd_data_reg;

    logic                      s1_tile_reg, s1_tile_next;
    logic                      s1_add_reg, s1_add_next;
    logic                      s1_emit_reg, s1_emit_next;
    logic                      s1_newline_reg, s1_newline_next;
    logic [tav_pkg::SEG_W-1:0] s1_seg_reg;
    logic [COL_W-1:0]          s1_idx_reg;
    logic [tav_pkg::SUM_W-1:0] total;

    // Fetch the band's partial sum for this tile column
    always_ff @(posedge aclk) begin
        if (accept && cmd.tile_done && cmd.add_mem) begin
            rd_data_reg <= band_mem[tile_idx];
        end
    end

    // Hold the segment and index next to the read in flight
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_seg_reg <= cmd.seg;
            s1_idx_reg <= tile_idx;
        end
    end

    always_comb begin
        s1_tile_next    = accept && cmd.tile_done;
        s1_add_next     = accept && cmd.add_mem;
        s1_emit_next    = accept && cmd.emit;
        s1_newline_next = accept && cmd.newline;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tile_reg    <= 1'b0;
            s1_add_reg     <= 1'b0;
            s1_emit_reg    <= 1'b0;
            s1_newline_reg <= 1'b0;
        end else begin
            s1_tile_reg    <= s1_tile_next;
            s1_add_reg     <= s1_add_next;
            s1_emit_reg    <= s1_emit_next;
            s1_newline_reg <= s1_newline_next;
        end
    end

    // Add the stored partial sum unless this is the band's first row
    always_comb begin
        total       = tav_pkg::SUM_W'(s1_seg_reg) + (s1_add_reg ? rd_data_reg : '0);
        res.emit    = s1_emit_reg;
        res.newline = s1_newline_reg;
        res.total   = total;
    end

    // Write back the partial sum on every row of the band but the last
    always_ff @(posedge aclk) begin
        if (s1_tile_reg && !s1_emit_reg) begin
            band_mem[s1_idx_reg] <= total;
        end
    end

endmodule

// ===== hw/rtl/tav_level_map.sv =====
module tav_level_map (
    input  logic                       aclk,
    input  logic [4:0]                 tile_size,
    input  logic [tav_pkg::SUM_W-1:0]  total,
    output logic [tav_pkg::CHAR_W-1:0] char_code
);

    logic [8:0]                tile_area;
    logic [tav_pkg::SUM_W-1:0] limit_next [tav_pkg::BOUNDS];
    logic [tav_pkg::SUM_W-1:0] limit_reg  [tav_pkg::BOUNDS];
    logic [3:0]                level;

    // Scale the level bounds by the tile area so no divide is needed
    always_comb begin
        tile_area = tav_pkg::tile_square(tile_size);
        for (int k = 0; k < tav_pkg::BOUNDS; k++) begin
            limit_next[k] = tav_pkg::SUM_W'(18'(tav_pkg::LEVEL_LIMIT_BASE[k]) * 18'(tile_area));
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg <= limit_next;
    end

    // Pick the first level whose scaled bound lies above the total
    always_comb begin
        level = 4'(tav_pkg::BOUNDS);
        for (int k = tav_pkg::BOUNDS - 1; k >= 0; k--) begin
            if (total < limit_reg[k]) begin
                level = 4'(k);
            end
        end
        char_code = tav_pkg::LEVEL_CHAR[level];
    end

endmodule

// ===== hw/rtl/tav_out_fifo.sv =====
module tav_out_fifo (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push_char,
    input  tav_pkg::out_word_t         char_word,
    input  logic                       push_newline,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [tav_pkg::CHAR_W-1:0] m_char_code,
    output logic                       m_last_of_run,
    output logic [2:0]                 count
);

    localparam int PTR_W = $clog2(tav_pkg::OUT_DEPTH);
    localparam int CNT_W = $clog2(tav_pkg::OUT_DEPTH + 1);

    tav_pkg::out_word_t entries [tav_pkg::OUT_DEPTH];
    tav_pkg::out_word_t nl_word;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   nl_ptr;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    always_comb begin
        m_valid           = count_reg != '0;
        m_char_code       = entries[rd_ptr_reg].char_code;
        m_last_of_run     = entries[rd_ptr_reg].last;
        count             = 3'(count_reg);
        nl_word.char_code = tav_pkg::NEWLINE_CODE;
        nl_word.last      = 1'b1;
        nl_ptr            = wr_ptr_reg + PTR_W'(push_char);
        pop               = m_valid && m_ready;
        wr_ptr_next       = wr_ptr_reg + PTR_W'(push_char) + PTR_W'(push_newline);
        rd_ptr_next       = rd_ptr_reg + PTR_W'(pop);
        count_next        = count_reg + CNT_W'(push_char) + CNT_W'(push_newline)
                            - CNT_W'(pop);
    end

    // Store the character word, then the newline word behind it
    always_ff @(posedge aclk) begin
        if (push_char) begin
            entries[wr_ptr_reg] <= char_word;
        end
        if (push_newline) begin
            entries[nl_ptr] <= nl_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/tile_average_to_ascii_top.sv =====
// Turns a raster stream of 8-bit grayscale pixels into ASCII art: each full
// tile_size x tile_size tile gives one character from "@%#*+=-:. " (dark to
// light) chosen by its truncated average, and each full band of tiles ends
// with a newline (10) on its last image row; partial tiles at the right and
// bottom edges are dropped. One pixel word is taken per clock while the
// four-word result queue has room for the two words the newest pixel may add
// on top of those still pending; results leave at one word per clock while
// m_ready is high, so a pixel's character and newline leave as two words.
// Results enter the queue in the cycle after their pixel is accepted: the
// accepting edge registers the read of the line store (one 16-bit entry per
// tile column, MAX_WIDTH deep, one read and one write port), and the cycle
// after it adds and maps the tile sum. A write to any of the three defined
// registers restarts the frame at its first pixel; the line store is kept and
// needs no clearing pass, since each band writes an entry on its first row
// before it reads it.
module tile_average_to_ascii_top #(
    parameter int MAX_WIDTH = tav_pkg::MAX_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_pixel_value,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tav_pkg::CHAR_W-1:0] m_char_code,
    output logic                       m_last_of_run,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [11:0]                cfg_data
);

    localparam int          COL_W = $clog2(MAX_WIDTH);
    localparam logic [13:0] W_LIM = 14'(MAX_WIDTH);
    localparam logic [11:0] WIDTH_RESET_C =
        (W_LIM < 14'(tav_pkg::WIDTH_RESET)) ? W_LIM[11:0] : tav_pkg::WIDTH_RESET;

    tav_pkg::cfg_t      cfg_reg, cfg_next;
    tav_pkg::scan_cmd_t cmd;
    tav_pkg::tile_res_t res;
    tav_pkg::out_word_t char_word;
    logic [COL_W-1:0]   tile_idx;
    logic [4:0]         ts_clamped;
    logic [11:0]        w_clamped;
    logic [11:0]        h_clamped;
    logic               restart;
    logic               accept;
    logic [tav_pkg::CHAR_W-1:0] mapped_char;
    logic [2:0]         fifo_count;
    logic [3:0]         room_need;

    // Clamp written values into their working ranges
    always_comb begin
        if (cfg_data[4:0] == 5'd0) begin
            ts_clamped = 5'd1;
        end else if (cfg_data[4:0] > 5'(tav_pkg::MAX_TILE)) begin
            ts_clamped = 5'(tav_pkg::MAX_TILE);
        end else begin
            ts_clamped = cfg_data[4:0];
        end

        if (cfg_data == 12'd0) begin
            w_clamped = 12'd1;
        end else if ({2'b00, cfg_data} > W_LIM) begin
            w_clamped = W_LIM[11:0];
        end else begin
            w_clamped = cfg_data;
        end

        if (cfg_data == 12'd0) begin
            h_clamped = 12'd1;
        end else if (cfg_data > 12'(tav_pkg::HEIGHT_LIMIT)) begin
            h_clamped = 12'(tav_pkg::HEIGHT_LIMIT);
        end else begin
            h_clamped = cfg_data;
        end
    end

    // Decode register writes
    always_comb begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        restart   = 1'b0;
        if (cfg_valid) begin
            case (tav_pkg::cfg_reg_t'(cfg_index))
                tav_pkg::REG_TILE_SIZE: begin
                    cfg_next.tile_size = ts_clamped;
                    restart            = 1'b1;
                end
                tav_pkg::REG_FRAME_WIDTH: begin
                    cfg_next.frame_width = w_clamped;
                    restart              = 1'b1;
                end
                tav_pkg::REG_FRAME_HEIGHT: begin
                    cfg_next.frame_height = h_clamped;
                    restart               = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tile_size    <= tav_pkg::TILE_RESET;
            cfg_reg.frame_width  <= WIDTH_RESET_C;
            cfg_reg.frame_height <= tav_pkg::HEIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Take a word only when the queue can hold everything still in flight
    always_comb begin
        room_need = 4'(fifo_count) + 4'(res.emit) + 4'(res.newline) + 4'd2;
        s_ready   = room_need <= 4'(tav_pkg::OUT_DEPTH);
        accept    = s_valid && s_ready;
    end

    tav_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .restart     (restart),
        .accept      (accept),
        .pixel_value (s_pixel_value),
        .cmd         (cmd),
        .tile_idx    (tile_idx)
    );

    tav_band_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_band_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .cmd      (cmd),
        .tile_idx (tile_idx),
        .res      (res)
    );

    tav_level_map u_level_map (
        .aclk      (aclk),
        .tile_size (cfg_reg.tile_size),
        .total     (res.total),
        .char_code (mapped_char)
    );

    always_comb begin
        char_word.char_code = mapped_char;
        char_word.last      = !res.newline;
    end

    tav_out_fifo u_out_fifo (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push_char     (res.emit),
        .char_word     (char_word),
        .push_newline  (res.newline),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_char_code   (m_char_code),
        .m_last_of_run (m_last_of_run),
        .count         (fifo_count)
    );

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.emit || res.newline) |->
            (4'(fifo_count) + 4'(res.emit) + 4'(res.newline) <= 4'(tav_pkg::OUT_DEPTH)))
        else $error("result queue overflow");

    a_push_after_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.emit || res.newline) |-> $past(s_valid && s_ready))
        else $error("result pushed without an accepted pixel word");

    a_newline_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_char_code == tav_pkg::NEWLINE_CODE)) |-> m_last_of_run)
        else $error("newline word not marked last");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Predicts the character stream of the tile averager and checks each output word
class ascii_scoreboard;
    int unsigned tile_reg;
    int unsigned width_reg;
    int unsigned height_reg;

    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned col_ph;
    int unsigned row_ph;
    int unsigned tile_col;
    int unsigned seg_sum;
    int unsigned band_sums [tav_pkg::MAX_WIDTH_DEF];

    int unsigned level_bound [9];
    byte         level_glyph [10];

    tav_pkg::out_word_t expected_words [$];
    int unsigned mismatches;
    int unsigned predicted;

    function new();
        tile_reg    = tav_pkg::TILE_RESET;
        width_reg   = tav_pkg::WIDTH_RESET;
        height_reg  = tav_pkg::HEIGHT_RESET;
        level_bound = '{31, 56, 81, 106, 131, 156, 181, 206, 231};
        level_glyph = '{"@", "%", "#", "*", "+", "=", "-", ":", ".", " "};
        foreach (band_sums[i]) band_sums[i] = 0;
        mismatches = 0;
        predicted  = 0;
        restart();
    endfunction

    // Clear the scan position; the band store is kept
    function void restart();
        col_pos  = 0;
        row_pos  = 0;
        col_ph   = 0;
        row_ph   = 0;
        tile_col = 0;
        seg_sum  = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function logic [6:0] glyph_of(int unsigned avg);
        for (int k = 0; k < 9; k++) begin
            if (avg <= level_bound[k]) return level_glyph[k][6:0];
        end
        return level_glyph[9][6:0];
    endfunction

    // Pixels in one band of the current setting
    function int unsigned band_pixels();
        return clamp(tile_reg, tav_pkg::MAX_TILE) * clamp(width_reg, tav_pkg::MAX_WIDTH_DEF);
    endfunction

    function int unsigned outstanding();
        return expected_words.size();
    endfunction

    function void note_config(logic [1:0] index, logic [11:0] data);
        if (index == tav_pkg::REG_TILE_SIZE) tile_reg = data[4:0];
        else if (index == tav_pkg::REG_FRAME_WIDTH) width_reg = data;
        else if (index == tav_pkg::REG_FRAME_HEIGHT) height_reg = data;
        else return;
        restart();
    endfunction

    function void note_pixel(logic [7:0] pix);
        int unsigned ts, w, h, full_cols, full_rows, seg, idx, tot, n;
        bit in_row, in_col, last_band_row;
        logic [6:0] codes [2];
        tav_pkg::out_word_t word;
        ts = clamp(tile_reg, tav_pkg::MAX_TILE);
        w  = clamp(width_reg, tav_pkg::MAX_WIDTH_DEF);
        h  = clamp(height_reg, tav_pkg::HEIGHT_LIMIT);
        full_cols = w - (w % ts);
        full_rows = h - (h % ts);
        in_row = row_pos < full_rows;
        in_col = col_pos < full_cols;
        last_band_row = in_row && (row_ph == ts - 1);
        n = 0;

        // accumulate the row segment, close the tile at its last column
        if (in_row && in_col) begin
            seg = (seg_sum + pix) & 'hFFF;
            if (col_ph == ts - 1) begin
                idx = tile_col & (tav_pkg::MAX_WIDTH_DEF - 1);
                tot = seg;
                if (row_ph != 0) tot = (tot + band_sums[idx]) & 'hFFFF;
                if (last_band_row) begin
                    codes[n] = glyph_of(tot / (ts * ts));
                    n++;
                end else begin
                    band_sums[idx] = tot;
                end
                seg_sum  = 0;
                tile_col = (tile_col + 1) & 'h7FF;
            end else begin
                seg_sum = seg;
            end
        end

        // advance the raster position, newline at the end of a band
        if (col_pos >= w - 1) begin
            if (last_band_row) begin
                codes[n] = tav_pkg::NEWLINE_CODE;
                n++;
            end
            col_pos  = 0;
            col_ph   = 0;
            tile_col = 0;
            seg_sum  = 0;
            if (row_pos >= h - 1) begin
                row_pos = 0;
                row_ph  = 0;
            end else begin
                row_pos = (row_pos + 1) & 'h7FF;
                row_ph  = (row_ph >= ts - 1) ? 0 : ((row_ph + 1) & 'hF);
            end
        end else begin
            col_pos = (col_pos + 1) & 'h7FF;
            col_ph  = (col_ph >= ts - 1) ? 0 : ((col_ph + 1) & 'hF);
        end

        for (int k = 0; k < n; k++) begin
            word.char_code = codes[k];
            word.last      = (k == n - 1);
            expected_words.push_back(word);
        end
        predicted += n;
    endfunction

    function void check_word(logic [6:0] char_code, logic last_of_run);
        tav_pkg::out_word_t want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual char %0d last %0d",
                     $time, char_code, last_of_run);
            mismatches++;
            return;
        end
        want = expected_words.pop_front();
        if (want.char_code !== char_code) begin
            $display("%0t: char_code mismatch, expected %0d actual %0d",
                     $time, want.char_code, char_code);
            mismatches++;
        end
        if (want.last !== last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %0d actual %0d",
                     $time, want.last, last_of_run);
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    localparam int unsigned RUN_LIMIT     = 1_000_000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned TAIL_CYCLES   = 16;
    localparam int unsigned RANDOM_PIXELS = 90;
    localparam int unsigned RANDOM_CHARS  = 16;
    localparam logic [1:0]  REG_SPARE     = 2'd3;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_pixel_value = 8'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [6:0]  m_char_code;
    logic        m_last_of_run;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = 2'd0;
    logic [11:0] cfg_data      = 12'd0;

    ascii_scoreboard sb;
    int unsigned     idle_mode   = 0;
    int unsigned     cycle_count = 0;
    int unsigned     random_sent = 0;
    logic [7:0]      level_probe [20];

    tile_average_to_ascii_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Idle modes: 0 none, 1 sender, 2 receiver, 3 both
    function automatic bit sender_holds();
        if (idle_mode == 1) return $urandom_range(0, 99) < 52;
        if (idle_mode == 3) return $urandom_range(0, 99) < 37;
        return 1'b0;
    endfunction

    function automatic bit receiver_holds();
        if (idle_mode == 2) return $urandom_range(0, 99) < 52;
        if (idle_mode == 3) return $urandom_range(0, 99) < 37;
        return 1'b0;
    endfunction

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready = aresetn && !receiver_holds();
    end

    // Note accepted words and check results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_pixel(s_pixel_value);
            if (m_valid && m_ready) sb.check_word(m_char_code, m_last_of_run);
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one pixel word and hold it until taken
    task automatic send_pixel(input logic [7:0] value);
        @(negedge aclk);
        while (sender_holds()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_pixel_value = value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [11:0] data);
        @(negedge aclk);
        s_valid   = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drop valid, drain expected words, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic configure(input int unsigned ts, input int unsigned w, input int unsigned h);
        logic [6:0] junk;
        junk = $urandom;
        settle();
        write_reg(tav_pkg::REG_TILE_SIZE, {junk, ts[4:0]});
        write_reg(tav_pkg::REG_FRAME_WIDTH, w[11:0]);
        write_reg(tav_pkg::REG_FRAME_HEIGHT, h[11:0]);
    endtask

    // Mix of full range, black/white and values near a per-phase level
    function automatic logic [7:0] pick_pixel(input int unsigned level);
        int unsigned v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 255);
            1: v = $urandom_range(0, 1) ? 255 : 0;
            default: begin
                v = level + $urandom_range(0, 12);
                v = (v > 6) ? v - 6 : 0;
                if (v > 255) v = 255;
            end
        endcase
        return v[7:0];
    endfunction

    task automatic stream(input int unsigned count);
        int unsigned level;
        level = $urandom_range(0, 255);
        repeat (count) send_pixel(pick_pixel(level));
    endtask

    task automatic random_phase(input int unsigned phase);
        int unsigned choice, ts, w, h, count;
        logic [11:0] data;
        choice = $urandom_range(0, 9);
        ts = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
        w  = $urandom_range(1, 24);
        h  = $urandom_range(1, 20);
        data = $urandom;
        idle_mode = phase % 4;
        if (choice < 7 || phase == 0) begin
            configure(ts, w, h);
        end else if (choice == 7) begin
            // rewrite one register, restarting the frame mid-band
            settle();
            case ($urandom_range(0, 2))
                0: write_reg(tav_pkg::REG_TILE_SIZE, data);
                1: write_reg(tav_pkg::REG_FRAME_WIDTH, 12'(w));
                default: write_reg(tav_pkg::REG_FRAME_HEIGHT, 12'(h));
            endcase
        end else if (choice == 8) begin
            // unused index: no restart, frame carries on
            settle();
            write_reg(REG_SPARE, data);
        end
        count = sb.band_pixels() * $urandom_range(1, 2) + $urandom_range(0, 8);
        if (count > 40) count = 40;
        stream(count);
        random_sent += count;
    endtask

    initial begin
        int unsigned phase;
        int unsigned chars_before;
        sb = new();
        level_probe = '{8'd0, 8'd31, 8'd32, 8'd56, 8'd57, 8'd81, 8'd82, 8'd106, 8'd107,
                        8'd131, 8'd132, 8'd156, 8'd157, 8'd181, 8'd182, 8'd206, 8'd207,
                        8'd231, 8'd232, 8'd255};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Tile size zero acts as one: each pixel maps straight to a level
        write_reg(tav_pkg::REG_TILE_SIZE, 12'd0);
        write_reg(tav_pkg::REG_FRAME_WIDTH, 12'd20);
        write_reg(tav_pkg::REG_FRAME_HEIGHT, 12'd1);
        foreach (level_probe[i]) send_pixel(level_probe[i]);

        // Oversized tile on a one-pixel frame: no full tile, no band
        configure(31, 1, 1);
        send_pixel(8'd255);
        send_pixel(8'd0);

        // Zero width and height act as one: character then newline per pixel
        configure(1, 0, 0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd0);

        // Largest tile, one frame
        idle_mode = 1;
        configure(16, 16, 16);
        stream(256);

        // Frame narrower than one tile, partial band at the bottom
        idle_mode = 2;
        configure(5, 3, 7);
        stream(21);

        // Width beyond the limit clamps, so the row runs on past these words
        idle_mode = 3;
        configure(1, 12'hFFF, 1);
        stream(16);

        // Height beyond and at the limit
        idle_mode = 0;
        configure(2, 5, 12'hFFF);
        stream(20);
        configure(4, 6, 2048);
        stream(24);

        // Random phases with settings mostly small
        chars_before = sb.predicted;
        phase = 0;
        while (random_sent < RANDOM_PIXELS || sb.predicted < chars_before + RANDOM_CHARS) begin
            random_phase(phase);
            phase++;
        end

        // Wait out the last results
        idle_mode = 0;
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tav_pkg.sv
hw/rtl/tav_scan.sv
hw/rtl/tav_band_store.sv
hw/rtl/tav_level_map.sv
hw/rtl/tav_out_fifo.sv
hw/rtl/tile_average_to_ascii_top.sv
verif/tb_top.sv
